// ----- sv/bb3_pkg.sv -----
// Shared constants, types and register codes for the 3x3 box blur block.
package bb3_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int CFG_W     = 12;
    localparam int WCMP_W    = (WID_W > CFG_W) ? WID_W : CFG_W;
    localparam int HGT_W     = 12;
    localparam int ROW_W     = HGT_W + 1;

    // Pixel and sum widths
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int SUM_W = 12;

    localparam logic [PIX_W-1:0] WHITE_PIX = {PIX_W{1'b1}};
    localparam logic [CH_W-1:0]  CH_MAX    = {CH_W{1'b1}};

    // Divide by nine: multiply by ceil(2^16 / 9) and keep the upper bits
    localparam int                     DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0]  DIV9_MUL   = 13'd7282;
    localparam int                     DIV9_SHIFT = 16;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);
    localparam int CRD_W  = QLVL_W + 1;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 12'd480;

    // Input operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Effective frame geometry
    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } geom_t;

    // One queued result: channel sums of a 3x3 window
    typedef struct packed {
        logic             last;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
    } sums_t;

endpackage

// ----- sv/bb3_front.sv -----
// Front end: position tracking, line stores, 3x3 window and channel sums.
module bb3_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bb3_pkg::geom_t             geom,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       operation,
    input  logic [bb3_pkg::CH_W-1:0]   in_red,
    input  logic [bb3_pkg::CH_W-1:0]   in_green,
    input  logic [bb3_pkg::CH_W-1:0]   in_blue,
    input  logic [bb3_pkg::QLVL_W-1:0] q_level,
    output logic                       push,
    output bb3_pkg::sums_t             push_data
);

    typedef struct packed {
        logic [bb3_pkg::COL_W-1:0] col;
        logic [bb3_pkg::PIX_W-1:0] pix;
        logic                      top_ok;
        logic                      mid_ok;
        logic                      emit;
        logic                      kind_a;
        logic                      rv0;
        logic                      rv2;
        logic                      cv0;
        logic                      last;
    } f1_t;

    // Position of the next beat
    logic [bb3_pkg::COL_W-1:0] col_reg;
    logic [bb3_pkg::ROW_W-1:0] row_reg;

    logic [bb3_pkg::COL_W-1:0]  c_norm, c;
    logic [bb3_pkg::ROW_W-1:0]  r_norm, r, h_ext;
    logic [bb3_pkg::WCMP_W-1:0] w_cmp;
    logic                       wrap, restart, due, ignore, accept, go;
    logic                       kind_a, emit_b, at_row_end;
    logic [bb3_pkg::COL_W-1:0]  col_next;
    logic [bb3_pkg::ROW_W-1:0]  row_next;
    f1_t                        f1_next;

    // Pipeline registers
    logic                      f1_valid_reg;
    f1_t                       f1_reg;
    logic                      f2_valid_reg;
    logic                      f2_last_reg;
    logic [bb3_pkg::PIX_W-1:0] taps_reg [3][3];
    logic [bb3_pkg::PIX_W-1:0] taps [3][3];

    // Line stores and bypass
    logic [bb3_pkg::PIX_W-1:0] upper_mem  [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0] middle_mem [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0] upper_q, middle_q;
    logic                      fwd_hit_reg;
    logic [bb3_pkg::PIX_W-1:0] fwd_up_reg, fwd_mid_reg;
    logic [bb3_pkg::PIX_W-1:0] up_data, mid_data, top_val, mid_val;

    // Window
    logic [bb3_pkg::PIX_W-1:0] win_reg [3][3];
    logic [bb3_pkg::PIX_W-1:0] col_new [3];

    logic                      f1_emit;
    logic [bb3_pkg::CRD_W-1:0] credit_used;

    // Hold off the source while the queue could overflow
    assign f1_emit     = f1_valid_reg && f1_reg.emit;
    assign credit_used = bb3_pkg::CRD_W'(q_level) + bb3_pkg::CRD_W'(f1_emit)
                       + bb3_pkg::CRD_W'(f2_valid_reg);
    assign in_stall    = credit_used >= bb3_pkg::CRD_W'(bb3_pkg::QDEPTH);
    assign accept      = in_valid && !in_stall;

    // Normalize the position and classify the beat
    always_comb
    begin
        w_cmp   = bb3_pkg::WCMP_W'(geom.width);
        h_ext   = bb3_pkg::ROW_W'(geom.height);
        wrap    = bb3_pkg::WCMP_W'(col_reg) >= w_cmp;
        c_norm  = wrap ? '0 : col_reg;
        r_norm  = wrap ? row_reg + bb3_pkg::ROW_W'(1) : row_reg;
        restart = r_norm > h_ext + bb3_pkg::ROW_W'(1);
        c       = restart ? '0 : c_norm;
        r       = restart ? '0 : r_norm;
        due     = r < h_ext;
        ignore  = due && (operation == bb3_pkg::OP_DRAIN);
        go      = accept && !ignore;

        kind_a     = (c == '0) && (r >= bb3_pkg::ROW_W'(2));
        emit_b     = (c != '0) && (r >= bb3_pkg::ROW_W'(1));
        at_row_end = bb3_pkg::WCMP_W'(c) + bb3_pkg::WCMP_W'(1) >= w_cmp;

        f1_next.col    = c;
        f1_next.pix    = due ? {in_red, in_green, in_blue} : bb3_pkg::WHITE_PIX;
        f1_next.top_ok = r >= bb3_pkg::ROW_W'(2);
        f1_next.mid_ok = r >= bb3_pkg::ROW_W'(1);
        f1_next.emit   = kind_a || emit_b;
        f1_next.kind_a = kind_a;
        f1_next.last   = kind_a && (r == h_ext + bb3_pkg::ROW_W'(1));
        if (kind_a)
        begin
            f1_next.rv0 = r >= bb3_pkg::ROW_W'(3);
            f1_next.rv2 = r <= h_ext;
            f1_next.cv0 = geom.width >= bb3_pkg::WID_W'(2);
        end
        else
        begin
            f1_next.rv0 = r >= bb3_pkg::ROW_W'(2);
            f1_next.rv2 = r < h_ext;
            f1_next.cv0 = c >= bb3_pkg::COL_W'(2);
        end

        if (f1_next.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (at_row_end)
        begin
            col_next = '0;
            row_next = r + bb3_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = c + bb3_pkg::COL_W'(1);
            row_next = r;
        end
    end

    // Advance the position on every accepted beat; a dropped drain only normalizes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (ignore)
            begin
                col_reg <= c;
                row_reg <= r;
            end
            else
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= go;
            fwd_hit_reg  <= go && f1_valid_reg && (f1_reg.col == c);
        end
    end

    // Stage one payload and bypass data
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            f1_reg <= f1_next;
        end
        fwd_up_reg  <= mid_val;
        fwd_mid_reg <= f1_reg.pix;
    end

    // Line stores: read at acceptance, written back from stage one in the following cycle
    always_ff @(posedge clk)
    begin
        if (f1_valid_reg)
        begin
            upper_mem[f1_reg.col]  <= mid_val;
            middle_mem[f1_reg.col] <= f1_reg.pix;
        end
        upper_q  <= upper_mem[c];
        middle_q <= middle_mem[c];
    end

    // Select bypassed data and build the new window column
    always_comb
    begin
        up_data    = fwd_hit_reg ? fwd_up_reg  : upper_q;
        mid_data   = fwd_hit_reg ? fwd_mid_reg : middle_q;
        top_val    = f1_reg.top_ok ? up_data  : bb3_pkg::WHITE_PIX;
        mid_val    = f1_reg.mid_ok ? mid_data : bb3_pkg::WHITE_PIX;
        col_new[0] = top_val;
        col_new[1] = mid_val;
        col_new[2] = f1_reg.pix;
    end

    // Pick the 3x3 taps; masked taps read as white
    always_comb
    begin
        logic [bb3_pkg::PIX_W-1:0] src;
        logic                      rv, cv;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (j == 2)
                begin
                    src = f1_reg.kind_a ? bb3_pkg::WHITE_PIX : col_new[i];
                end
                else
                begin
                    src = win_reg[i][j+1];
                end
                rv = (i == 0) ? f1_reg.rv0 : ((i == 2) ? f1_reg.rv2 : 1'b1);
                cv = (j == 0) ? f1_reg.cv0 : ((j == 2) ? !f1_reg.kind_a : 1'b1);
                taps[i][j] = (rv && cv) ? src : bb3_pkg::WHITE_PIX;
            end
        end
    end

    // Shift the window on every item that reaches stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= bb3_pkg::WHITE_PIX;
                end
            end
        end
        else if (f1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
                win_reg[i][2] <= col_new[i];
            end
        end
    end

    // Stage two control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f2_valid_reg <= f1_emit;
        end
    end

    // Stage two payload
    always_ff @(posedge clk)
    begin
        if (f1_emit)
        begin
            taps_reg    <= taps;
            f2_last_reg <= f1_reg.last;
        end
    end

    // Sum each channel row by row, then across rows
    always_comb
    begin
        logic [bb3_pkg::SUM_W-1:0] row_r [3];
        logic [bb3_pkg::SUM_W-1:0] row_g [3];
        logic [bb3_pkg::SUM_W-1:0] row_b [3];
        for (int i = 0; i < 3; i++)
        begin
            row_r[i] = '0;
            row_g[i] = '0;
            row_b[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                row_r[i] = row_r[i] + bb3_pkg::SUM_W'(taps_reg[i][j][23:16]);
                row_g[i] = row_g[i] + bb3_pkg::SUM_W'(taps_reg[i][j][15:8]);
                row_b[i] = row_b[i] + bb3_pkg::SUM_W'(taps_reg[i][j][7:0]);
            end
        end
        push_data.last  = f2_last_reg;
        push_data.sum_r = row_r[0] + row_r[1] + row_r[2];
        push_data.sum_g = row_g[0] + row_g[1] + row_g[2];
        push_data.sum_b = row_b[0] + row_b[1] + row_b[2];
    end

    assign push = f2_valid_reg;

    a_f2_from_f1: assert property (@(posedge clk) disable iff (!rst_n)
        f2_valid_reg |-> $past(f1_valid_reg && f1_reg.emit))
        else $error("stage two loaded without an emitting stage one item");

    a_fwd_needs_writer: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> $past(f1_valid_reg) && f1_valid_reg)
        else $error("line store bypass without a pending write");

endmodule

// ----- sv/bb3_fifo.sv -----
// Short result queue between the front end and the output stage.
module bb3_fifo
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bb3_pkg::sums_t             push_data,
    input  logic                       pop,
    output bb3_pkg::sums_t             head,
    output logic [bb3_pkg::QLVL_W-1:0] level
);

    bb3_pkg::sums_t                   mem_reg [bb3_pkg::QDEPTH];
    logic [bb3_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [bb3_pkg::QLVL_W-1:0]       level_reg;

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bb3_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bb3_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + bb3_pkg::QLVL_W'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - bb3_pkg::QLVL_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign level = level_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg < bb3_pkg::QLVL_W'(bb3_pkg::QDEPTH)) || pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level_reg != '0)
        else $error("pop from an empty queue");

endmodule

// ----- sv/bb3_back.sv -----
// Output stage: divides the queued sums by nine into the output register.
module bb3_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bb3_pkg::sums_t           head,
    input  logic                     q_nonempty,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [bb3_pkg::CH_W-1:0] avg_red,
    output logic [bb3_pkg::CH_W-1:0] avg_green,
    output logic [bb3_pkg::CH_W-1:0] avg_blue,
    output logic                     frame_end
);

    localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::DIV9_MUL_W;

    logic                     out_valid_reg;
    logic [bb3_pkg::CH_W-1:0] red_reg, green_reg, blue_reg;
    logic                     frame_end_reg;
    logic                     load;

    // Truncated division by nine through the reciprocal
    function automatic logic [bb3_pkg::CH_W-1:0] div9(input logic [bb3_pkg::SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(bb3_pkg::DIV9_MUL);
        return p[bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
    endfunction

    // Refill the output register when empty or taken
    assign load = !out_valid_reg || !out_stall;
    assign pop  = q_nonempty && load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= q_nonempty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            red_reg       <= div9(head.sum_r);
            green_reg     <= div9(head.sum_g);
            blue_reg      <= div9(head.sum_b);
            frame_end_reg <= head.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign avg_red   = red_reg;
    assign avg_green = green_reg;
    assign avg_blue  = blue_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- sv/box_blur_3x3_rgb_core.sv -----
// Top level of the 3x3 RGB box blur: configuration registers and the filter datapath.
// Accepts one beat per clock and sustains one result per clock when out_stall is
// low; that rate is set by the two line stores, each doing one read and one write
// per cycle, with a same-address bypass so a one-pixel-wide image still runs at full
// rate. A result passes stage one, stage two and the result queue before the output register.
// Pixels arrive in raster order; the mean for a pixel leaves one row plus one pixel
// later, so after the last pixel send width + 1 drain beats (operation = 1) to flush
// the final row; the last result carries frame_end. A drain beat sent while pixels
// are still due is dropped. Neighbors outside the image count as white. Line stores
// need no clearing pass after reset. Write image_width (0x0) and image_height (0x4)
// only while the block is idle.
module box_blur_3x3_rgb_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bb3_pkg::ADDR_W-1:0]  paddr,
    input  logic [bb3_pkg::DATA_W-1:0]  pwdata,
    output logic [bb3_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [bb3_pkg::CH_W-1:0]    in_red,
    input  logic [bb3_pkg::CH_W-1:0]    in_green,
    input  logic [bb3_pkg::CH_W-1:0]    in_blue,
    // Output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bb3_pkg::CH_W-1:0]    avg_red,
    output logic [bb3_pkg::CH_W-1:0]    avg_green,
    output logic [bb3_pkg::CH_W-1:0]    avg_blue,
    output logic [bb3_pkg::CH_W-1:0]    out_alpha,
    output logic                        frame_end
);

    logic [bb3_pkg::CFG_W-1:0]  width_reg;
    logic [bb3_pkg::HGT_W-1:0]  height_reg;
    logic                       cfg_write;
    bb3_pkg::geom_t             geom;

    logic                       push, pop;
    bb3_pkg::sums_t             push_data, head;
    logic [bb3_pkg::QLVL_W-1:0] q_level;

    // Write configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bb3_pkg::WIDTH_RESET;
            height_reg <= bb3_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                bb3_pkg::REG_IDX_WIDTH:  width_reg  <= pwdata[bb3_pkg::CFG_W-1:0];
                bb3_pkg::REG_IDX_HEIGHT: height_reg <= pwdata[bb3_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            bb3_pkg::REG_IDX_WIDTH:  prdata = bb3_pkg::DATA_W'(width_reg);
            bb3_pkg::REG_IDX_HEIGHT: prdata = bb3_pkg::DATA_W'(height_reg);
            default:                 prdata = '0;
        endcase
    end

    // Clamp the geometry into the supported range
    always_comb
    begin
        if (width_reg == '0)
        begin
            geom.width = bb3_pkg::WID_W'(1);
        end
        else if (bb3_pkg::WCMP_W'(width_reg) > bb3_pkg::WCMP_W'(bb3_pkg::MAX_WIDTH))
        begin
            geom.width = bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH);
        end
        else
        begin
            geom.width = bb3_pkg::WID_W'(width_reg);
        end
        geom.height = (height_reg == '0) ? bb3_pkg::HGT_W'(1) : height_reg;
    end

    bb3_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .q_level   (q_level),
        .push      (push),
        .push_data (push_data)
    );

    bb3_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .level     (q_level)
    );

    bb3_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_nonempty (q_level != '0),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .avg_red    (avg_red),
        .avg_green  (avg_green),
        .avg_blue   (avg_blue),
        .frame_end  (frame_end)
    );

    assign out_alpha = bb3_pkg::CH_MAX;

endmodule

// ----- tb/tb_box_blur_3x3_rgb_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 RGB box blur core: random frames checked against a window predictor.
module tb_box_blur_3x3_rgb_core;

    localparam int     HALF_PERIOD   = 10;
    localparam int     TAPS          = 9;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     RANDOM_BEATS  = 1400;
    localparam int     MAX_REPORTS   = 50;
    localparam longint TIMEOUT_NS    = 30_000_000;

    // One expected blur result
    typedef struct packed {
        logic [bb3_pkg::CH_W-1:0] red;
        logic [bb3_pkg::CH_W-1:0] green;
        logic [bb3_pkg::CH_W-1:0] blue;
        logic                     last;
    } mean_t;

    // Tracks frame position, line stores and 3x3 window; queues the expected means
    class box_mean_board;
        int unsigned                        width_reg;
        int unsigned                        height_reg;
        bit [bb3_pkg::PIX_W-1:0]            upper_row [bb3_pkg::MAX_WIDTH];
        bit [bb3_pkg::PIX_W-1:0]            middle_row [bb3_pkg::MAX_WIDTH];
        bit [2:0][2:0][bb3_pkg::PIX_W-1:0]  taps;
        int unsigned                        col;
        int unsigned                        row;
        mean_t                              pending_means [$];
        int                                 mismatches;

        function new();
            width_reg  = 32'(bb3_pkg::WIDTH_RESET);
            height_reg = 32'(bb3_pkg::HEIGHT_RESET);
            // Window starts all white
            taps       = '1;
            col        = 0;
            row        = 0;
            mismatches = 0;
        endfunction

        function int unsigned clamp_width(int unsigned w);
            if (w == 0)
                return 1;
            if (w > bb3_pkg::MAX_WIDTH)
                return bb3_pkg::MAX_WIDTH;
            return w;
        endfunction

        function int unsigned active_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function bit at_frame_start();
            return (row == 0) && (col == 0);
        endfunction

        function mean_t window_mean(bit [2:0][2:0][bb3_pkg::PIX_W-1:0] blk, bit [2:0] rv,
                                    bit [2:0] cv, bit last);
            int                      sum_r;
            int                      sum_g;
            int                      sum_b;
            bit [bb3_pkg::PIX_W-1:0] p;
            mean_t                   m;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            // Taps outside the image count as white
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p = (rv[i] && cv[j]) ? blk[i][j] : bb3_pkg::WHITE_PIX;
                    sum_r += int'(p[2*bb3_pkg::CH_W +: bb3_pkg::CH_W]);
                    sum_g += int'(p[bb3_pkg::CH_W +: bb3_pkg::CH_W]);
                    sum_b += int'(p[0 +: bb3_pkg::CH_W]);
                end
            end
            m.red   = bb3_pkg::CH_W'(sum_r / TAPS);
            m.green = bb3_pkg::CH_W'(sum_g / TAPS);
            m.blue  = bb3_pkg::CH_W'(sum_b / TAPS);
            m.last  = last;
            return m;
        endfunction

        // Advance on one accepted beat; returns 0 when the block drops it
        function bit take_pixel_beat(logic op, logic [bb3_pkg::PIX_W-1:0] beat_pix);
            int unsigned                        w;
            int unsigned                        h;
            bit [bb3_pkg::PIX_W-1:0]            pix;
            bit [bb3_pkg::PIX_W-1:0]            top;
            bit [bb3_pkg::PIX_W-1:0]            mid;
            bit [2:0][2:0][bb3_pkg::PIX_W-1:0]  blk;
            bit [2:0]                           rv;
            bit [2:0]                           cv;
            bit                                 last;
            w    = clamp_width(width_reg);
            h    = active_height();
            pix  = beat_pix;
            last = 1'b0;
            // End a row cut short by a narrower width; restart once past the final flush
            if (col >= w)
            begin
                col = 0;
                row++;
            end
            if (row > h + 1)
            begin
                col = 0;
                row = 0;
            end
            // Drop drains while pixels are due; past the last row every beat is white
            if (row < h)
            begin
                if (op == bb3_pkg::OP_DRAIN)
                    return 1'b0;
            end
            else
            begin
                pix = bb3_pkg::WHITE_PIX;
            end
            // Finish the last pixel of the row two above
            if (col == 0 && row >= 2)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    blk[i][0] = taps[i][1];
                    blk[i][1] = taps[i][2];
                    blk[i][2] = bb3_pkg::WHITE_PIX;
                end
                rv   = {(row - 1) < h, 1'b1, row >= 3};
                cv   = {1'b0, 1'b1, w >= 2};
                last = (row - 2) == (h - 1);
                pending_means.push_back(window_mean(blk, rv, cv, last));
            end
            // Rotate the line stores and shift the window
            top = (row >= 2) ? upper_row[col] : bb3_pkg::WHITE_PIX;
            mid = (row >= 1) ? middle_row[col] : bb3_pkg::WHITE_PIX;
            upper_row[col]  = mid;
            middle_row[col] = pix;
            for (int i = 0; i < 3; i++)
            begin
                taps[i][0] = taps[i][1];
                taps[i][1] = taps[i][2];
            end
            taps[0][2] = top;
            taps[1][2] = mid;
            taps[2][2] = pix;
            // Mean of the pixel one row and one column back
            if (col >= 1 && row >= 1)
            begin
                rv   = {row < h, 1'b1, row >= 2};
                cv   = {1'b1, 1'b1, col >= 2};
                last = ((row - 1) == (h - 1)) && ((col - 1) == (w - 1));
                pending_means.push_back(window_mean(taps, rv, cv, last));
            end
            // Advance the position
            if (last)
            begin
                col = 0;
                row = 0;
            end
            else if (col + 1 >= w)
            begin
                col = 0;
                row++;
            end
            else
            begin
                col++;
            end
            return 1'b1;
        endfunction

        task report_mismatch(string what, logic [bb3_pkg::DATA_W-1:0] got,
                             logic [bb3_pkg::DATA_W-1:0] want);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        endtask

        task check_mean(logic [bb3_pkg::CH_W-1:0] r, logic [bb3_pkg::CH_W-1:0] g,
                        logic [bb3_pkg::CH_W-1:0] b, logic [bb3_pkg::CH_W-1:0] a, logic fe);
            mean_t want;
            if (pending_means.size() == 0)
            begin
                report_mismatch("result with no pending mean",
                                bb3_pkg::DATA_W'({r, g, b}), '0);
                return;
            end
            want = pending_means.pop_front();
            if (r !== want.red)
                report_mismatch("avg_red", bb3_pkg::DATA_W'(r), bb3_pkg::DATA_W'(want.red));
            if (g !== want.green)
                report_mismatch("avg_green", bb3_pkg::DATA_W'(g),
                                bb3_pkg::DATA_W'(want.green));
            if (b !== want.blue)
                report_mismatch("avg_blue", bb3_pkg::DATA_W'(b), bb3_pkg::DATA_W'(want.blue));
            if (a !== bb3_pkg::CH_MAX)
                report_mismatch("out_alpha", bb3_pkg::DATA_W'(a),
                                bb3_pkg::DATA_W'(bb3_pkg::CH_MAX));
            if (fe !== want.last)
                report_mismatch("frame_end", bb3_pkg::DATA_W'(fe),
                                bb3_pkg::DATA_W'(want.last));
        endtask
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [bb3_pkg::ADDR_W-1:0]    paddr     = '0;
    logic [bb3_pkg::DATA_W-1:0]    pwdata    = '0;
    logic [bb3_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic                          operation = bb3_pkg::OP_PIXEL;
    logic [bb3_pkg::CH_W-1:0]      in_red    = '0;
    logic [bb3_pkg::CH_W-1:0]      in_green  = '0;
    logic [bb3_pkg::CH_W-1:0]      in_blue   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [bb3_pkg::CH_W-1:0]      avg_red;
    logic [bb3_pkg::CH_W-1:0]      avg_green;
    logic [bb3_pkg::CH_W-1:0]      avg_blue;
    logic [bb3_pkg::CH_W-1:0]      out_alpha;
    logic                          frame_end;

    box_mean_board                 board;
    int                            idle_pct      = 0;
    int                            counted_beats = 0;
    int                            stall_left    = 0;
    logic [bb3_pkg::PIX_W-1:0]     corner_pix [9] = '{24'h000000, 24'hFFFFFF, 24'hFF0080,
                                                      24'h00FF01, 24'hAA55FE, 24'h55AA7F,
                                                      24'h0180FF, 24'h800100, 24'hFE7FAA};

    box_blur_3x3_rgb_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .avg_red   (avg_red),
        .avg_green (avg_green),
        .avg_blue  (avg_blue),
        .out_alpha (out_alpha),
        .frame_end (frame_end)
    );

    always #HALF_PERIOD clk = ~clk;

    // Stall the output in random bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left <= $urandom_range(0, 6);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_mean(avg_red, avg_green, avg_blue, out_alpha, frame_end);
    end

    // Send one beat, with an optional gap first; call and return at a falling edge
    task automatic send_beat(logic op, logic [bb3_pkg::PIX_W-1:0] pix);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        in_red    <= pix[2*bb3_pkg::CH_W +: bb3_pkg::CH_W];
        in_green  <= pix[bb3_pkg::CH_W +: bb3_pkg::CH_W];
        in_blue   <= pix[0 +: bb3_pkg::CH_W];
        do
            @(posedge clk);
        while (in_stall);
        if (board.take_pixel_beat(op, pix))
            counted_beats++;
        @(negedge clk);
    endtask

    // Hold off until every pending mean has arrived and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // APB write followed by a readback of the same register
    task automatic write_reg(logic idx, int unsigned value);
        logic [bb3_pkg::DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == bb3_pkg::REG_IDX_WIDTH)
            board.width_reg = value;
        else
            board.height_reg = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (got[bb3_pkg::CFG_W-1:0] !== value[bb3_pkg::CFG_W-1:0])
            board.report_mismatch(idx == bb3_pkg::REG_IDX_WIDTH ? "image_width readback"
                                                                : "image_height readback",
                                  got, value);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h);
        int unsigned new_w;
        settle();
        new_w = w;
        // Never widen mid-frame: the extra columns of the line stores hold nothing yet
        if (!board.at_frame_start() &&
            board.clamp_width(w) > board.clamp_width(board.width_reg))
            new_w = board.width_reg;
        write_reg(bb3_pkg::REG_IDX_WIDTH, new_w);
        write_reg(bb3_pkg::REG_IDX_HEIGHT, h);
    endtask

    task automatic send_pixels(int unsigned n, bit noisy);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_beat(bb3_pkg::OP_DRAIN, bb3_pkg::PIX_W'($urandom));
            send_beat(bb3_pkg::OP_PIXEL, bb3_pkg::PIX_W'($urandom));
        end
    endtask

    // Flush with drains, some replaced by pixels that act as drains
    task automatic send_flush(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_beat(bb3_pkg::OP_PIXEL, bb3_pkg::PIX_W'($urandom));
            else
                send_beat(bb3_pkg::OP_DRAIN, bb3_pkg::PIX_W'($urandom));
        end
    endtask

    task automatic finish_frame();
        while (!board.at_frame_start())
            send_beat(bb3_pkg::OP_PIXEL, bb3_pkg::PIX_W'($urandom));
    endtask

    function automatic int unsigned pick_width();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel <= 2)
            return $urandom_range(13, 40);
        return $urandom_range(1, 12);
    endfunction

    function automatic int unsigned pick_height();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return $urandom_range(9, 20);
        return $urandom_range(1, 8);
    endfunction

    initial
    begin
        int unsigned kind;
        int unsigned fw;
        int unsigned fh;
        board = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: 3x3 frame with extreme channels, a dropped drain and a pixel used as drain
        idle_pct = 0;
        set_geometry(3, 3);
        send_beat(bb3_pkg::OP_DRAIN, 24'h123456);
        foreach (corner_pix[i])
            send_beat(bb3_pkg::OP_PIXEL, corner_pix[i]);
        repeat (3) send_beat(bb3_pkg::OP_DRAIN, 24'h000000);
        send_beat(bb3_pkg::OP_PIXEL, 24'hA5A5A5);
        // Single pixel frame, then zero width and height acting as one
        set_geometry(1, 1);
        send_beat(bb3_pkg::OP_PIXEL, 24'hFFFFFF);
        repeat (2) send_beat(bb3_pkg::OP_DRAIN, 24'hFFFFFF);
        set_geometry(0, 0);
        send_beat(bb3_pkg::OP_PIXEL, 24'h000000);
        send_beat(bb3_pkg::OP_PIXEL, 24'h010203);
        send_beat(bb3_pkg::OP_DRAIN, 24'h000000);

        // Register extremes: width above the store size and tallest frame, each cut short
        idle_pct = 30;
        set_geometry(4095, 4095);
        send_pixels(60, 1'b0);
        set_geometry(16, 1);
        finish_frame();
        set_geometry(0, 4095);
        send_pixels(30, 1'b0);
        set_geometry(0, 0);
        finish_frame();

        // Random frames; mostly well formed, some cut short, reshaped or left unflushed
        counted_beats = 0;
        while (counted_beats < RANDOM_BEATS)
        begin
            kind = $urandom_range(0, 9);
            if (counted_beats > RANDOM_BEATS * 85 / 100)
                idle_pct = 0;
            else
                idle_pct = 25 * $urandom_range(0, 2);
            if (kind <= 6)
                finish_frame();
            set_geometry(pick_width(), pick_height());
            fw = board.clamp_width(board.width_reg);
            fh = board.active_height();
            case (kind)
                7:
                begin
                    // Narrow width or height part way through the frame
                    send_pixels($urandom_range(1, fw * fh), 1'b0);
                    if ($urandom_range(0, 1) != 0)
                        set_geometry($urandom_range(1, fw), board.height_reg);
                    else
                        set_geometry(board.width_reg, $urandom_range(0, fh));
                    finish_frame();
                end
                8:
                begin
                    // No flush: the next frame's pixels drain this one
                    send_pixels(fw * fh, 1'b0);
                end
                9:
                begin
                    send_pixels(fw * fh, 1'b1);
                    send_flush($urandom_range(0, fw + 3));
                end
                default:
                begin
                    send_pixels(fw * fh, kind < 2);
                    send_flush(fw + 1);
                end
            endcase
        end

        // Wait out the pipeline and report
        idle_pct = 0;
        settle();
        if (board.mismatches == 0 && board.pending_means.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
